@@ rtl/nsf_pkg.sv @@
// Shared widths, constants and the divider status type for the night schedule fade block.
// No dependencies; used by nsf_div and night_schedule_fade.
package nsf_pkg;

	localparam int MIN_W  = 11;              // minute of day and fade length
	localparam int STR_W  = 8;               // Q0.8 strength
	localparam int ALPHA_W = 6;              // strength / 4
	localparam int PROD_W = MIN_W + STR_W;   // minutes times peak

	localparam logic [MIN_W-1:0] LAST_MINUTE = 11'd1439;
	localparam logic [MIN_W-1:0] DAY_MINUTES = 11'd1440;
	localparam logic [STR_W-1:0] HYST_UNITS  = 8'd3;

	// Divider status seen by the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} nsf_div_sts_t;

endpackage

@@ rtl/nsf_div.sv @@
// Serial restoring divider for the ramp fraction, one quotient bit per cycle.
// Depends on nsf_pkg. The quotient is known to fit in STR_W bits.
module nsf_div import nsf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [MIN_W-1:0]  divisor,
	output nsf_div_sts_t      sts,
	output logic [STR_W-1:0]  quotient
);

	localparam int CNT_W = $clog2(STR_W);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STR_W - 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MIN_W-1:0] rem_q;
	logic [STR_W-1:0] sh_q;
	logic [STR_W-1:0] q_q;

	logic [MIN_W:0]   trial;
	logic [MIN_W:0]   trial_sub;
	logic             step_bit;
	logic [MIN_W-1:0] step_rem;

	// One restoring step: bring down the next dividend bit, subtract if it fits
	always_comb begin
		trial     = {rem_q, sh_q[STR_W-1]};
		trial_sub = trial - {1'b0, divisor};
		step_bit  = (trial >= {1'b0, divisor});
		step_rem  = step_bit ? trial_sub[MIN_W-1:0] : trial[MIN_W-1:0];
	end

	// Step count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient; the top bits of the dividend start below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:STR_W];
			sh_q  <= dividend[STR_W-1:0];
			q_q   <= '0;
		end else if (busy_q) begin
			rem_q <= step_rem;
			sh_q  <= {sh_q[STR_W-2:0], 1'b0};
			q_q   <= {q_q[STR_W-2:0], step_bit};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = q_q;

endmodule

@@ rtl/night_schedule_fade.sv @@
// Night schedule fade: window test, linear ramp and hysteresis on the applied strength.
// Path: a request taken in idle goes to the window test with the light on, or straight to the update
// with the light off; a ramp adds a multiply, then the 8-step serial divider, before the update.
// Requests: a new one is taken only in idle, after the last result is registered; a stalled output holds the update.
// Reset (arst_n low, asynchronous): registers to defaults, night inactive, strength 0.
module night_schedule_fade import nsf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// Tick requests
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MIN_W-1:0]   minute_of_day,
	// Results
	output logic               out_valid,
	input  logic               out_ready,
	output logic               night_on,
	output logic               apply_pulse,
	output logic [STR_W-1:0]   tint_strength,
	output logic [ALPHA_W-1:0] tint_alpha
);

	localparam logic [2:0] REG_LIGHT_EN = 3'd0;
	localparam logic [2:0] REG_FADE_EN  = 3'd1;
	localparam logic [2:0] REG_START    = 3'd2;
	localparam logic [2:0] REG_END      = 3'd3;
	localparam logic [2:0] REG_FADE_LEN = 3'd4;
	localparam logic [2:0] REG_PEAK     = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_DIV,
		ST_UPD
	} state_t;

	// Configuration registers
	logic             light_en_q;
	logic             fade_en_q;
	logic [MIN_W-1:0] start_q;
	logic [MIN_W-1:0] end_q;
	logic [MIN_W-1:0] fade_q;
	logic [STR_W-1:0] peak_q;

	logic       cfg_wr;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;

	// Write registers on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_en_q <= 1'b0;
			fade_en_q  <= 1'b1;
			start_q    <= 11'd1200;
			end_q      <= 11'd360;
			fade_q     <= 11'd30;
			peak_q     <= 8'd204;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_LIGHT_EN: light_en_q <= pwdata[0];
				REG_FADE_EN:  fade_en_q  <= pwdata[0];
				REG_START:    start_q    <= pwdata[MIN_W-1:0];
				REG_END:      end_q      <= pwdata[MIN_W-1:0];
				REG_FADE_LEN: fade_q     <= pwdata[MIN_W-1:0];
				REG_PEAK:     peak_q     <= pwdata[STR_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (reg_idx)
			REG_LIGHT_EN: prdata = {31'd0, light_en_q};
			REG_FADE_EN:  prdata = {31'd0, fade_en_q};
			REG_START:    prdata = {{(32-MIN_W){1'b0}}, start_q};
			REG_END:      prdata = {{(32-MIN_W){1'b0}}, end_q};
			REG_FADE_LEN: prdata = {{(32-MIN_W){1'b0}}, fade_q};
			REG_PEAK:     prdata = {{(32-STR_W){1'b0}}, peak_q};
			default:      prdata = '0;
		endcase
	end

	// Sequencer state and datapath registers
	state_t            state_q;
	logic [MIN_W-1:0]  cur_q;
	logic              dis_q;
	logic              act_q;
	logic [MIN_W-1:0]  num_q;
	logic [STR_W-1:0]  target_q;
	logic [PROD_W-1:0] prod_q;
	logic              div_start_q;
	logic              night_q;
	logic [STR_W-1:0]  applied_q;
	logic              out_valid_q;
	logic              night_on_q;
	logic              pulse_q;
	logic [STR_W-1:0]  strength_q;

	nsf_div_sts_t     div_sts;
	logic [STR_W-1:0] div_quot;

	nsf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (prod_q),
		.divisor  (fade_q),
		.sts      (div_sts),
		.quotient (div_quot)
	);

	// Window test and ramp distances
	logic [MIN_W-1:0] s_sat, e_sat, in_sat;
	logic             wrap, act_c;
	logic [MIN_W-1:0] since_c, total_c, until_c;
	logic             ramp_in, ramp_out;

	always_comb begin
		s_sat  = (start_q > LAST_MINUTE) ? LAST_MINUTE : start_q;
		e_sat  = (end_q > LAST_MINUTE) ? LAST_MINUTE : end_q;
		in_sat = (minute_of_day > LAST_MINUTE) ? LAST_MINUTE : minute_of_day;
		wrap   = (s_sat > e_sat);
		if (wrap)
			act_c = (cur_q >= s_sat) || (cur_q < e_sat);
		else
			act_c = (cur_q >= s_sat) && (cur_q < e_sat);
		since_c  = (cur_q >= s_sat) ? (cur_q - s_sat) : (DAY_MINUTES - s_sat + cur_q);
		total_c  = wrap ? (DAY_MINUTES - s_sat + e_sat) : (e_sat - s_sat);
		until_c  = total_c - since_c;
		ramp_in  = (since_c < fade_q);
		ramp_out = (until_c < fade_q);
	end

	// Hysteresis on the applied strength
	logic [STR_W-1:0] diff_c;
	logic             out_free;
	logic             upd_night, upd_pulse;
	logic [STR_W-1:0] upd_strength;

	always_comb begin
		diff_c   = (applied_q > target_q) ? (applied_q - target_q) : (target_q - applied_q);
		out_free = !out_valid_q || out_ready;
		if (dis_q) begin
			upd_night    = 1'b0;
			upd_pulse    = night_q;
			upd_strength = night_q ? '0 : applied_q;
		end else begin
			upd_night    = act_q;
			upd_pulse    = (diff_c >= HYST_UNITS);
			upd_strength = upd_pulse ? target_q : applied_q;
		end
	end

	// Sequence one request: window, multiply and divide when ramping, update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			div_start_q <= 1'b0;
			night_q     <= 1'b0;
			applied_q   <= '0;
			out_valid_q <= 1'b0;
			night_on_q  <= 1'b0;
			pulse_q     <= 1'b0;
			strength_q  <= '0;
			cur_q       <= '0;
			dis_q       <= 1'b0;
			act_q       <= 1'b0;
			num_q       <= '0;
			target_q    <= '0;
			prod_q      <= '0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cur_q   <= in_sat;
						dis_q   <= !light_en_q;
						state_q <= light_en_q ? ST_CALC : ST_UPD;
					end
				end
				ST_CALC: begin
					act_q   <= act_c;
					state_q <= ST_UPD;
					if (!act_c) begin
						target_q <= '0;
					end else if (!fade_en_q || (fade_q == '0)) begin
						target_q <= peak_q;
					end else if (ramp_in) begin
						num_q   <= since_c;
						state_q <= ST_MUL;
					end else if (ramp_out) begin
						num_q   <= until_c;
						state_q <= ST_MUL;
					end else begin
						target_q <= peak_q;
					end
				end
				ST_MUL: begin
					prod_q      <= PROD_W'(num_q) * PROD_W'(peak_q);
					div_start_q <= 1'b1;
					state_q     <= ST_DIV;
				end
				ST_DIV: begin
					if (div_sts.done) begin
						target_q <= div_quot;
						state_q  <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (out_free) begin
						night_q     <= upd_night;
						applied_q   <= upd_strength;
						night_on_q  <= upd_night;
						pulse_q     <= upd_pulse;
						strength_q  <= upd_strength;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign out_valid     = out_valid_q;
	assign night_on      = night_on_q;
	assign apply_pulse   = pulse_q;
	assign tint_strength = strength_q;
	assign tint_alpha    = strength_q[STR_W-1:STR_W-ALPHA_W];

`ifndef SYNTHESIS
	// Divider finishes only while the sequencer waits on it
	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == ST_DIV))
		else $error("divider done outside divide state");

	// A ramp quotient never exceeds the peak strength
	a_quot_le_peak: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (div_quot <= peak_q))
		else $error("ramp quotient above peak");

	// No second request is taken right after one is accepted
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while busy");

	// Applied strength changes only on a result that carries the apply pulse
	a_pulse_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		(applied_q != $past(applied_q)) |-> (pulse_q && out_valid_q))
		else $error("strength changed without apply pulse");
`endif

endmodule

@@ verif/night_schedule_fade_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for night_schedule_fade: minute-of-day requests in, window flag and
// hysteresis-filtered tint strength out, checked against an in-bench predictor of the schedule.
// Depends on nsf_pkg and night_schedule_fade from the rtl folder.
module night_schedule_fade_test;
	import nsf_pkg::*;

	// Register byte addresses on the APB port
	localparam logic [4:0] REG_LIGHT_EN  = 5'd0;
	localparam logic [4:0] REG_FADE_EN   = 5'd4;
	localparam logic [4:0] REG_START     = 5'd8;
	localparam logic [4:0] REG_END       = 5'd12;
	localparam logic [4:0] REG_FADE_LEN  = 5'd16;
	localparam logic [4:0] REG_PEAK      = 5'd20;

	localparam int SETTLE_CYCLES = 20;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SQUEEZE_AT    = 450;
	localparam int SQUEEZE_LEN   = 300;
	localparam int SWEEPS        = 10;
	localparam int SWEEP_TICKS   = 100;

	typedef struct packed {
		logic               night;
		logic               pulse;
		logic [STR_W-1:0]   strength;
		logic [ALPHA_W-1:0] alpha;
	} tick_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [MIN_W-1:0]   minute_of_day = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               night_on;
	logic               apply_pulse;
	logic [STR_W-1:0]   tint_strength;
	logic [ALPHA_W-1:0] tint_alpha;

	// Shadow of the configuration and of the block's state
	logic               cfg_light_en = 1'b0;
	logic               cfg_fade_en = 1'b1;
	logic [MIN_W-1:0]   cfg_start = 11'd1200;
	logic [MIN_W-1:0]   cfg_end = 11'd360;
	logic [MIN_W-1:0]   cfg_fade_len = 11'd30;
	logic [STR_W-1:0]   cfg_peak = 8'd204;
	logic               night_act = 1'b0;
	logic [STR_W-1:0]   applied_str = '0;

	logic [MIN_W-1:0]   pending_minutes[$];
	tick_result_t       expected_ticks[$];

	logic in_took = 1'b0;
	logic squeezed = 1'b0;
	int   gap_left = 0;
	int   stall_left = 0;
	int   idle_pct = 25;
	int   results_seen = 0;
	int   err_count = 0;
	int   quiet_cycles = 0;

	night_schedule_fade u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.minute_of_day (minute_of_day),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.night_on      (night_on),
		.apply_pulse   (apply_pulse),
		.tint_strength (tint_strength),
		.tint_alpha    (tint_alpha)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int clamp_minute(input logic [MIN_W-1:0] v);
		return (v > LAST_MINUTE) ? int'(LAST_MINUTE) : int'(v);
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(3, 1);
		if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic logic [MIN_W-1:0] pick_bound();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return LAST_MINUTE;
		if (r < 15)
			return MIN_W'($urandom_range(2047, 1440));
		return MIN_W'($urandom_range(1439, 0));
	endfunction

	// Advance the schedule state for one tick and queue the result it yields
	task automatic predict_tick(input logic [MIN_W-1:0] raw);
		int cur, s, e, since, total, to_end, tgt, diff;
		logic act;
		tick_result_t r;
		r.pulse = 1'b0;
		if (!cfg_light_en) begin
			// drop the tint only if it was on; a residual strength is kept otherwise
			if (night_act) begin
				night_act = 1'b0;
				applied_str = '0;
				r.pulse = 1'b1;
			end
		end else begin
			cur = clamp_minute(raw);
			s = clamp_minute(cfg_start);
			e = clamp_minute(cfg_end);
			act = (s > e) ? (cur >= s || cur < e) : (cur >= s && cur < e);
			tgt = 0;
			if (act && (!cfg_fade_en || cfg_fade_len == 0)) begin
				tgt = int'(cfg_peak);
			end else if (act) begin
				// ramp-in wins over ramp-out when the fade outlasts the window
				since = (cur >= s) ? cur - s : DAY_MINUTES - s + cur;
				total = (s > e) ? DAY_MINUTES - s + e : e - s;
				to_end = total - since;
				if (since < cfg_fade_len)
					tgt = since * cfg_peak / cfg_fade_len;
				else if (to_end < cfg_fade_len)
					tgt = to_end * cfg_peak / cfg_fade_len;
				else
					tgt = int'(cfg_peak);
			end
			night_act = act;
			diff = (applied_str > tgt) ? applied_str - tgt : tgt - applied_str;
			if (diff >= HYST_UNITS) begin
				applied_str = tgt[STR_W-1:0];
				r.pulse = 1'b1;
			end
		end
		r.night = night_act;
		r.strength = applied_str;
		r.alpha = applied_str[STR_W-1:2];
		expected_ticks.push_back(r);
	endtask

	// APB write: setup cycle, access cycle, then release; mirror into the shadow copy
	task automatic write_reg(input logic [4:0] addr, input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_LIGHT_EN: cfg_light_en = value[0];
			REG_FADE_EN:  cfg_fade_en = value[0];
			REG_START:    cfg_start = value[MIN_W-1:0];
			REG_END:      cfg_end = value[MIN_W-1:0];
			REG_FADE_LEN: cfg_fade_len = value[MIN_W-1:0];
			REG_PEAK:     cfg_peak = value[STR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int light, input int fade, input int s, input int e,
			input int flen, input int pk);
		write_reg(REG_LIGHT_EN, light);
		write_reg(REG_FADE_EN, fade);
		write_reg(REG_START, s);
		write_reg(REG_END, e);
		write_reg(REG_FADE_LEN, flen);
		write_reg(REG_PEAK, pk);
	endtask

	// Wait until every request is sent and every result is back, then let the block settle
	task automatic drain();
		do
			@(posedge clk);
		while (pending_minutes.size() != 0 || in_valid || expected_ticks.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Request driver: hold until taken, insert random gaps, pull from the pending queue
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_took) begin
			// hold the request until it is accepted
		end else if (gap_left > 0) begin
			gap_left--;
			in_valid <= 1'b0;
		end else if (pending_minutes.size() != 0 && $urandom_range(99) < idle_pct) begin
			gap_left = gap_len() - 1;
			in_valid <= 1'b0;
		end else if (pending_minutes.size() != 0) begin
			minute_of_day <= pending_minutes.pop_front();
			in_valid <= 1'b1;
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Result receiver: random stalls, plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (!squeezed && results_seen >= SQUEEZE_AT) begin
			squeezed = 1'b1;
			stall_left = SQUEEZE_LEN;
			out_ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if ($urandom_range(99) < idle_pct) begin
			stall_left = gap_len() - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Monitor: predict on each accepted request, compare each accepted result
	always @(posedge clk) begin
		tick_result_t want;
		in_took = arst_n && in_valid && in_ready;
		if (in_took)
			predict_tick(minute_of_day);
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_ticks.size() == 0) begin
				err_count++;
				$error("result with no request outstanding");
			end else begin
				want = expected_ticks.pop_front();
				if (night_on !== want.night) begin
					err_count++;
					$error("night_on: expected %0d, got %0d", want.night, night_on);
				end
				if (apply_pulse !== want.pulse) begin
					err_count++;
					$error("apply_pulse: expected %0d, got %0d", want.pulse, apply_pulse);
				end
				if (tint_strength !== want.strength) begin
					err_count++;
					$error("tint_strength: expected %0d, got %0d", want.strength,
						tint_strength);
				end
				if (tint_alpha !== want.alpha) begin
					err_count++;
					$error("tint_alpha: expected %0d, got %0d", want.alpha, tint_alpha);
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles < IDLE_LIMIT) begin
			quiet_cycles <= quiet_cycles + 1;
		end else begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		int cursor, anchor, r;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Light off from reset: nothing turns on, whatever the minute
		pending_minutes.push_back(11'd0);
		pending_minutes.push_back(11'd1439);
		pending_minutes.push_back(11'd2047);
		drain();

		// Overnight window with ramps at both edges, saturated minute inside it
		write_all(1, 1, 1200, 360, 30, 204);
		pending_minutes = '{11'd1199, 11'd1200, 11'd1214, 11'd1229, 11'd1230, 11'd2047,
			11'd0, 11'd335, 11'd345, 11'd359, 11'd360, 11'd1300};
		drain();

		// Disable while active, then again while inactive
		write_reg(REG_LIGHT_EN, 0);
		pending_minutes = '{11'd1300, 11'd1300};
		drain();

		// Empty window
		write_all(1, 1, 500, 500, 30, 204);
		pending_minutes.push_back(11'd500);
		drain();

		// Saturated start bound with a zero-length fade
		write_all(1, 1, 2047, 100, 0, 255);
		pending_minutes = '{11'd1439, 11'd50, 11'd100};
		drain();

		// Fade longer than the window
		write_all(1, 1, 100, 110, 1440, 255);
		pending_minutes = '{11'd100, 11'd109};
		drain();

		// Ramp-out leaves a residual strength below the hysteresis step
		write_all(1, 1, 200, 260, 30, 30);
		pending_minutes = '{11'd230, 11'd258, 11'd262};
		drain();
		write_reg(REG_FADE_EN, 0);
		pending_minutes.push_back(11'd240);
		drain();

		// Random sweeps: mostly walks across window edges, some scattered minutes
		for (int ph = 0; ph < SWEEPS; ph++) begin
			idle_pct = (ph % 3 == 2) ? 0 : 25;
			if (ph == 0)
				write_all(1, 1, 2047, 0, 2047, 255);
			else if (ph == 1)
				write_all(1, 0, 0, 1439, 0, 0);
			else
				write_all(int'($urandom_range(9) != 0), $urandom_range(1),
					int'(pick_bound()),
					($urandom_range(9) == 0) ? int'(cfg_start) : int'(pick_bound()),
					($urandom_range(9) == 0) ? 0 :
					($urandom_range(4) == 0) ? $urandom_range(2047, 0) :
					$urandom_range(60, 1),
					($urandom_range(9) == 0) ? 255 : $urandom_range(255));
			cursor = (clamp_minute(cfg_start) + 1440 - $urandom_range(10)) % 1440;
			for (int i = 0; i < SWEEP_TICKS; i++) begin
				r = $urandom_range(99);
				if (r < 10) begin
					pending_minutes.push_back(MIN_W'($urandom_range(2047)));
				end else begin
					if (r < 15) begin
						anchor = clamp_minute($urandom_range(1) ? cfg_start : cfg_end);
						cursor = (anchor + 1440 - $urandom_range(40)) % 1440;
					end
					cursor = (cursor + $urandom_range(2)) % 1440;
					pending_minutes.push_back(MIN_W'(cursor));
				end
			end
			drain();
		end

		if (err_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
